// ===== rtl/cle_pkg.sv =====
// shared constants and result type of the console line editor
package cle_pkg;

   // default ring depth in bytes
   localparam int DEFAULT_BUFFER_DEPTH = 128;

   // request operation codes
   localparam logic OP_RX_CHAR = 1'b0;
   localparam logic OP_READ    = 1'b1;

   // control characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_CTRL_C = 8'h03;
   localparam logic [7:0] CH_CTRL_D = 8'h04;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_CTRL_U = 8'h15;
   localparam logic [7:0] CH_DELETE = 8'h7F;

   // erase count saturates here
   localparam logic [7:0] ERASE_MAX = 8'hFF;

   // one result transfer
   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_char;
      logic [7:0] erase_count;
      logic       line_ready;
      logic       interrupt_request;
      logic       read_valid;
      logic [7:0] read_char;
      logic       read_empty;
      logic       end_of_file;
   } rsp_type;

endpackage

// ===== rtl/console_line_editor.sv =====
// console line editor: canonical line buffer in a ring memory
//
//   channel   handshake            payload
//   request   start / busy         req_operation, req_rx_char, req_read_started
//   result    rsp_strobe (1 cycle) rsp_echo_valid ... rsp_end_of_file
//
// A received character or an empty read gives its result in the cycle after the
// transfer; a read of a stored byte first passes the registered memory read and ST_READ_WAIT.
// Kill-line walks back over the erased characters and stops at the commit point or
// at a newline: each step is one read of the ring memory and one compare.
// Synchronous reset clears the three pointers; the ring contents stay undefined.
// busy is high while a read or a kill-line is in progress; results cannot be held off.
module console_line_editor #(
   parameter int BUFFER_DEPTH = cle_pkg::DEFAULT_BUFFER_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_operation,
   input  logic [7:0] req_rx_char,
   input  logic       req_read_started,
   output logic       rsp_strobe,
   output logic       rsp_echo_valid,
   output logic [7:0] rsp_echo_char,
   output logic [7:0] rsp_erase_count,
   output logic       rsp_line_ready,
   output logic       rsp_interrupt_request,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_char,
   output logic       rsp_read_empty,
   output logic       rsp_end_of_file
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int PW = $clog2(2 * BUFFER_DEPTH);
   localparam logic [PW-1:0] PTR_LAST   = PW'(2 * BUFFER_DEPTH - 1);
   localparam logic [PW-1:0] PTR_DEPTH  = PW'(BUFFER_DEPTH);
   localparam logic [PW-1:0] PTR_DEPTH1 = PW'(BUFFER_DEPTH - 1);
   localparam logic [PW:0]   PTR_SPAN   = (PW+1)'(2 * BUFFER_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_KILL_LOOK,
      ST_KILL_CHECK
   } state_type;

   // pointer arithmetic modulo twice the depth
   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] ptr_prev(input logic [PW-1:0] p);
      return (p == '0) ? PTR_LAST : p - PW'(1);
   endfunction

   function automatic logic [PW-1:0] ptr_dist(input logic [PW-1:0] ahead,
                                              input logic [PW-1:0] behind);
      logic [PW:0] wrapped;
      wrapped = {1'b0, ahead} + PTR_SPAN - {1'b0, behind};
      return (ahead >= behind) ? ahead - behind : wrapped[PW-1:0];
   endfunction

   function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
      logic [PW-1:0] s;
      s = (p >= PTR_DEPTH) ? p - PTR_DEPTH : p;
      return s[AW-1:0];
   endfunction

   state_type         state_ff;
   logic [PW-1:0]     read_ptr_ff;
   logic [PW-1:0]     commit_ptr_ff;
   logic [PW-1:0]     edit_ptr_ff;
   logic [7:0]        kill_count_ff;
   logic              started_ff;
   cle_pkg::rsp_type  rsp_ff;
   logic              rsp_strobe_ff;

   logic [7:0]        line_store [BUFFER_DEPTH];
   logic [7:0]        rd_data_ff;

   logic              accept;
   logic [7:0]        stored_char;
   logic [PW-1:0]     fill;
   logic              room;
   logic              ordinary;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic              mem_wr_en;

   // request decode
   always_comb begin
      accept      = start && (state_ff == ST_IDLE);
      stored_char = (req_rx_char == cle_pkg::CH_CR) ? cle_pkg::CH_LF : req_rx_char;
      fill        = ptr_dist(edit_ptr_ff, read_ptr_ff);
      room        = fill < PTR_DEPTH;
      ordinary    = (req_rx_char != cle_pkg::CH_NUL) &&
                    (req_rx_char != cle_pkg::CH_CTRL_C) &&
                    (req_rx_char != cle_pkg::CH_CTRL_U) &&
                    (req_rx_char != cle_pkg::CH_DELETE);
   end

   // memory port control
   always_comb begin
      mem_wr_en   = accept && (req_operation == cle_pkg::OP_RX_CHAR) && ordinary && room;
      mem_rd_en   = 1'b0;
      mem_rd_addr = slot_of(read_ptr_ff);
      if (state_ff == ST_KILL_LOOK) begin
         mem_rd_en   = edit_ptr_ff != commit_ptr_ff;
         mem_rd_addr = slot_of(ptr_prev(edit_ptr_ff));
      end else if (accept && (req_operation == cle_pkg::OP_READ)) begin
         mem_rd_en   = read_ptr_ff != commit_ptr_ff;
      end
   end

   // ring memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         line_store[slot_of(edit_ptr_ff)] <= stored_char;
      end
      if (mem_rd_en) begin
         rd_data_ff <= line_store[mem_rd_addr];
      end
   end

   // sequencer, pointers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         read_ptr_ff   <= '0;
         commit_ptr_ff <= '0;
         edit_ptr_ff   <= '0;
         kill_count_ff <= '0;
         started_ff    <= 1'b0;
         rsp_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_ff     <= '0;
                  started_ff <= req_read_started;
                  if (req_operation == cle_pkg::OP_READ) begin
                     if (read_ptr_ff == commit_ptr_ff) begin
                        rsp_ff.read_empty <= 1'b1;
                        rsp_strobe_ff     <= 1'b1;
                     end else begin
                        state_ff <= ST_READ_WAIT;
                     end
                  end else if (req_rx_char == cle_pkg::CH_CTRL_U) begin
                     kill_count_ff <= '0;
                     state_ff      <= ST_KILL_LOOK;
                  end else begin
                     rsp_strobe_ff <= 1'b1;
                     if (req_rx_char == cle_pkg::CH_CTRL_C) begin
                        rsp_ff.interrupt_request <= 1'b1;
                     end else if (req_rx_char == cle_pkg::CH_DELETE) begin
                        if (edit_ptr_ff != commit_ptr_ff) begin
                           edit_ptr_ff        <= ptr_prev(edit_ptr_ff);
                           rsp_ff.erase_count <= 8'd1;
                        end
                     end else if (ordinary && room) begin
                        edit_ptr_ff       <= ptr_next(edit_ptr_ff);
                        rsp_ff.echo_valid <= 1'b1;
                        rsp_ff.echo_char  <= stored_char;
                        // commit on newline, end-of-file or a ring that is now full
                        if ((stored_char == cle_pkg::CH_LF) ||
                            (stored_char == cle_pkg::CH_CTRL_D) ||
                            (fill == PTR_DEPTH1)) begin
                           commit_ptr_ff     <= ptr_next(edit_ptr_ff);
                           rsp_ff.line_ready <= 1'b1;
                        end
                     end
                  end
               end
            end
            ST_READ_WAIT: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
               if (rd_data_ff == cle_pkg::CH_CTRL_D) begin
                  // end-of-file stays in place once the read has delivered bytes
                  rsp_ff.end_of_file <= 1'b1;
                  if (!started_ff) begin
                     read_ptr_ff <= ptr_next(read_ptr_ff);
                  end
               end else begin
                  read_ptr_ff       <= ptr_next(read_ptr_ff);
                  rsp_ff.read_valid <= 1'b1;
                  rsp_ff.read_char  <= rd_data_ff;
               end
            end
            ST_KILL_LOOK: begin
               // stop at the commit point, else look at the previous byte
               if (edit_ptr_ff == commit_ptr_ff) begin
                  rsp_ff.erase_count <= kill_count_ff;
                  rsp_strobe_ff      <= 1'b1;
                  state_ff           <= ST_IDLE;
               end else begin
                  state_ff <= ST_KILL_CHECK;
               end
            end
            ST_KILL_CHECK: begin
               if (rd_data_ff == cle_pkg::CH_LF) begin
                  rsp_ff.erase_count <= kill_count_ff;
                  rsp_strobe_ff      <= 1'b1;
                  state_ff           <= ST_IDLE;
               end else begin
                  edit_ptr_ff <= ptr_prev(edit_ptr_ff);
                  if (kill_count_ff != cle_pkg::ERASE_MAX) begin
                     kill_count_ff <= kill_count_ff + 8'd1;
                  end
                  state_ff <= ST_KILL_LOOK;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // outputs
   assign busy                  = state_ff != ST_IDLE;
   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_echo_valid        = rsp_ff.echo_valid;
   assign rsp_echo_char         = rsp_ff.echo_char;
   assign rsp_erase_count       = rsp_ff.erase_count;
   assign rsp_line_ready        = rsp_ff.line_ready;
   assign rsp_interrupt_request = rsp_ff.interrupt_request;
   assign rsp_read_valid        = rsp_ff.read_valid;
   assign rsp_read_char         = rsp_ff.read_char;
   assign rsp_read_empty        = rsp_ff.read_empty;
   assign rsp_end_of_file       = rsp_ff.end_of_file;

endmodule

// ===== tb/sv/console_line_editor_test.sv =====
// testbench for the console line editor: random key and read traffic checked against a line model
`timescale 1ns / 1ps

module console_line_editor_test;

   localparam int DEPTH       = cle_pkg::DEFAULT_BUFFER_DEPTH;
   localparam int PTR_W       = $clog2(2 * DEPTH);
   localparam int SLOT_W      = $clog2(DEPTH);
   localparam int KEY_TARGET  = 750;
   localparam int QUIET_TAIL  = 80;
   localparam int STALL_LIMIT = 8 * (2 + 2 * DEPTH) + 64;

   typedef struct {
      logic       op;
      logic [7:0] ch;
      logic       started;
   } key_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       start            = 1'b0;
   logic       req_operation    = cle_pkg::OP_RX_CHAR;
   logic [7:0] req_rx_char      = cle_pkg::CH_NUL;
   logic       req_read_started = 1'b0;
   logic       busy;
   logic       rsp_strobe;
   logic       rsp_echo_valid;
   logic [7:0] rsp_echo_char;
   logic [7:0] rsp_erase_count;
   logic       rsp_line_ready;
   logic       rsp_interrupt_request;
   logic       rsp_read_valid;
   logic [7:0] rsp_read_char;
   logic       rsp_read_empty;
   logic       rsp_end_of_file;

   key_type          pending_keys[$];
   cle_pkg::rsp_type expected_replies[$];
   int               mismatches = 0;
   int               keys_sent  = 0;
   bit               key_taken  = 1'b0;
   int               gap_left   = 0;

   // line model state
   logic [7:0]       line_ring[DEPTH];
   logic [PTR_W-1:0] read_ptr   = '0;
   logic [PTR_W-1:0] commit_ptr = '0;
   logic [PTR_W-1:0] edit_ptr   = '0;

   console_line_editor #(.BUFFER_DEPTH(DEPTH)) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_operation         (req_operation),
      .req_rx_char           (req_rx_char),
      .req_read_started      (req_read_started),
      .rsp_strobe            (rsp_strobe),
      .rsp_echo_valid        (rsp_echo_valid),
      .rsp_echo_char         (rsp_echo_char),
      .rsp_erase_count       (rsp_erase_count),
      .rsp_line_ready        (rsp_line_ready),
      .rsp_interrupt_request (rsp_interrupt_request),
      .rsp_read_valid        (rsp_read_valid),
      .rsp_read_char         (rsp_read_char),
      .rsp_read_empty        (rsp_read_empty),
      .rsp_end_of_file       (rsp_end_of_file)
   );

   always #10 clock = ~clock;

   // ring slot of a model pointer
   function automatic logic [SLOT_W-1:0] slot_of(logic [PTR_W-1:0] p);
      return SLOT_W'(p % PTR_W'(DEPTH));
   endfunction

   // apply one key or read to the line model and return the reply it gives
   function automatic cle_pkg::rsp_type edit_line(key_type k);
      cle_pkg::rsp_type r;
      logic [7:0]       c;
      logic [PTR_W-1:0] span;
      int unsigned      erased;
      r = '0;
      erased = 0;
      if (k.op == cle_pkg::OP_READ) begin
         if (read_ptr == commit_ptr) begin
            r.read_empty = 1'b1;
         end else begin
            c = line_ring[slot_of(read_ptr)];
            if (c == cle_pkg::CH_CTRL_D) begin
               // end-of-file stays in place once the read has delivered bytes
               if (!k.started) read_ptr = read_ptr + PTR_W'(1);
               r.end_of_file = 1'b1;
            end else begin
               read_ptr = read_ptr + PTR_W'(1);
               r.read_valid = 1'b1;
               r.read_char  = c;
            end
         end
      end else if (k.ch == cle_pkg::CH_NUL) begin
         r = '0;
      end else if (k.ch == cle_pkg::CH_CTRL_C) begin
         r.interrupt_request = 1'b1;
      end else if (k.ch == cle_pkg::CH_CTRL_U) begin
         // kill back to the last newline
         while (edit_ptr != commit_ptr &&
                line_ring[slot_of(edit_ptr - PTR_W'(1))] != cle_pkg::CH_LF) begin
            edit_ptr = edit_ptr - PTR_W'(1);
            erased++;
         end
         r.erase_count = (erased > cle_pkg::ERASE_MAX) ? cle_pkg::ERASE_MAX : erased[7:0];
      end else if (k.ch == cle_pkg::CH_DELETE) begin
         if (edit_ptr != commit_ptr) begin
            edit_ptr = edit_ptr - PTR_W'(1);
            r.erase_count = 8'd1;
         end
      end else begin
         span = edit_ptr - read_ptr;
         if (span < DEPTH) begin
            c = (k.ch == cle_pkg::CH_CR) ? cle_pkg::CH_LF : k.ch;
            line_ring[slot_of(edit_ptr)] = c;
            edit_ptr = edit_ptr + PTR_W'(1);
            r.echo_valid = 1'b1;
            r.echo_char  = c;
            span = edit_ptr - read_ptr;
            if (c == cle_pkg::CH_LF || c == cle_pkg::CH_CTRL_D || span == DEPTH) begin
               commit_ptr = edit_ptr;
               r.line_ready = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // stimulus helpers
   task automatic push_rx(logic [7:0] ch);
      key_type k;
      k.op = cle_pkg::OP_RX_CHAR;
      k.ch = ch;
      k.started = 1'($urandom_range(0, 1));
      pending_keys.push_back(k);
   endtask

   task automatic push_read(logic started);
      key_type k;
      k.op = cle_pkg::OP_READ;
      k.ch = 8'($urandom_range(0, 255));
      k.started = started;
      pending_keys.push_back(k);
   endtask

   // ordinary byte that neither edits nor commits, high half included
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(8'h20, 8'hFF));
      if (c == cle_pkg::CH_DELETE) c = 8'h7E;
      return c;
   endfunction

   task automatic type_line();
      int len;
      len = $urandom_range(0, 12);
      repeat (len) begin
         case ($urandom_range(0, 15))
            0:       push_rx(cle_pkg::CH_DELETE);
            1:       push_rx(cle_pkg::CH_CTRL_U);
            2:       push_rx(cle_pkg::CH_CTRL_C);
            3:       push_rx(8'($urandom_range(0, 255)));
            default: push_rx(plain_char());
         endcase
      end
      case ($urandom_range(0, 5))
         0:       push_rx(cle_pkg::CH_CR);
         1:       push_rx(cle_pkg::CH_CTRL_D);
         2:       ;
         default: push_rx(cle_pkg::CH_LF);
      endcase
      repeat ($urandom_range(0, len + 3)) push_read(1'($urandom_range(0, 1)));
   endtask

   // directed opening, then random line traffic with one ring fill and one long kill
   initial begin
      bit filled;
      bit killed;
      filled = 1'b0;
      killed = 1'b0;
      push_read(1'b0);
      push_rx(cle_pkg::CH_NUL);
      push_rx(8'h61);
      push_rx(cle_pkg::CH_CR);
      push_read(1'b0);
      push_read(1'b1);
      push_read(1'b0);
      push_rx(8'hFF);
      push_rx(8'h80);
      push_rx(cle_pkg::CH_DELETE);
      push_rx(cle_pkg::CH_DELETE);
      push_rx(cle_pkg::CH_DELETE);
      push_rx(cle_pkg::CH_CTRL_C);
      push_rx(8'h78);
      push_rx(8'h79);
      push_rx(cle_pkg::CH_CTRL_U);
      push_rx(8'h7A);
      push_rx(cle_pkg::CH_LF);
      push_read(1'b0);
      push_read(1'b1);
      push_rx(cle_pkg::CH_CTRL_D);
      push_read(1'b1);
      push_read(1'b0);
      push_read(1'b0);
      while (pending_keys.size() < KEY_TARGET) begin
         if (!filled && pending_keys.size() > 250) begin
            // drain, overfill the ring, drain again
            filled = 1'b1;
            repeat (20) push_read(1'b0);
            repeat ($urandom_range(DEPTH + 2, DEPTH + 8)) push_rx(plain_char());
            repeat (DEPTH + 4) push_read(1'($urandom_range(0, 1)));
         end else if (!killed && pending_keys.size() > 450) begin
            killed = 1'b1;
            repeat (20) push_read(1'b0);
            repeat ($urandom_range(DEPTH - 28, DEPTH - 1)) push_rx(plain_char());
            push_rx(cle_pkg::CH_CTRL_U);
         end else begin
            case ($urandom_range(0, 9))
               0: repeat ($urandom_range(1, 6)) begin
                     if ($urandom_range(0, 1)) push_read(1'($urandom_range(0, 1)));
                     else push_rx(8'($urandom_range(0, 255)));
                  end
               1: repeat ($urandom_range(1, 8)) push_read(1'($urandom_range(0, 1)));
               default: type_line();
            endcase
         end
      end
   end

   // reset, then wait for the traffic to drain
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_keys.size() != 0 || expected_replies.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 8) @(posedge clock);
      if (mismatches == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   // driver: next request at the falling edge, with random gaps
   always @(negedge clock) begin
      bit calm;
      calm = (pending_keys.size() < QUIET_TAIL) || ((keys_sent / 50) % 3 == 2);
      if (reset || (start && !key_taken)) begin
         // hold the request until it transfers
      end else if (gap_left != 0) begin
         gap_left = gap_left - 1;
         start <= 1'b0;
      end else if (pending_keys.size() != 0 && !calm && $urandom_range(0, 3) == 0) begin
         gap_left = $urandom_range(0, 2);
         start <= 1'b0;
      end else if (pending_keys.size() != 0) begin
         start            <= 1'b1;
         req_operation    <= pending_keys[0].op;
         req_rx_char      <= pending_keys[0].ch;
         req_read_started <= pending_keys[0].started;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: check replies, then predict for the request that transfers
   always @(posedge clock) begin
      cle_pkg::rsp_type got;
      cle_pkg::rsp_type want;
      key_type          k;
      key_taken = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            got = '{rsp_echo_valid, rsp_echo_char, rsp_erase_count, rsp_line_ready,
                    rsp_interrupt_request, rsp_read_valid, rsp_read_char,
                    rsp_read_empty, rsp_end_of_file};
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected reply, expected none actual %h", $time, got);
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               if (got !== want) begin
                  $display("%0t: reply mismatch, expected %h actual %h", $time, want, got);
                  mismatches++;
               end
            end
         end
         if (start && !busy && pending_keys.size() != 0) begin
            k = pending_keys.pop_front();
            expected_replies.push_back(edit_line(k));
            keys_sent++;
            key_taken = 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe) stall = 0;
         else stall++;
      end
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/cle_pkg.sv
rtl/console_line_editor.sv
tb/sv/console_line_editor_test.sv
